### rtl/core/arlt_pkg.sv
// Shared types and codes for the address region table lookup block.
package arlt_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_CHECK = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_UNUSABLE = 3'd1;
    localparam logic [2:0] STAT_ZERO     = 3'd2;
    localparam logic [2:0] STAT_STOPPED  = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OUT,
        S_AD_CHK,
        S_AD_END,
        S_AD_SUM,
        S_AD_PSUM,
        S_CK_MID,
        S_CK_CMP,
        S_CK_IN,
        S_CK_TOP,
        S_CK_FIT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // carry: carry out for add, borrow for subtract
    typedef struct packed {
        logic [63:0] value;
        logic        carry;
        logic        zero;
    } alu_res_t;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] limit;
        logic        exec;
        logic        priv;
    } entry_t;

endpackage

### rtl/core/arlt_mem.sv
// Region table memory: one write port, one registered read port.
module arlt_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  arlt_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output arlt_pkg::entry_t rdata
);
    import arlt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/arlt_alu.sv
// Shared 64-bit add/subtract unit used for every address and total computation.
module arlt_alu (
    input  arlt_pkg::alu_op_t  op,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output arlt_pkg::alu_res_t res
);
    import arlt_pkg::*;

    logic [63:0] b_eff;
    logic [64:0] full;
    logic        is_sub;

    assign is_sub = (op == ALU_SUB);
    assign b_eff  = is_sub ? ~b : b;
    assign full   = {1'b0, a} + {1'b0, b_eff} + {64'd0, is_sub};

    always_comb
    begin
        res.value = full[63:0];
        // invert carry into borrow on subtract
        res.carry = is_sub ? ~full[64] : full[64];
        res.zero  = (full[63:0] == 64'd0);
    end

endmodule

### rtl/core/address_region_table_lookup.sv
// Top level of the address region table: sequencer, state and result registers.
//
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+---------------------------
//  command  | opcode address length index committed      | taken when start && !busy
//           | readable_prot executable_prot blocked_prot |
//           | private_type                               |
//  result   | hit readable_ok executable priv_mark       | valid for one cycle on done
//           | merged status region_start region_end      |
//           | region_count total_bytes private_bytes     |
//
// Transaction steps, from acceptance to done:
//   clear finishes at acceptance; read entry fetches the entry, then reports it; add checks
//   order, writes the entry, then updates the totals; check runs k search steps, where k is
//   at most ceil(log2(region_count + 1)), then tests the found region and the range fit.
// Each binary search step costs one read of the table memory port plus one
// compare in the shared 64-bit adder; adds use the same adder for end and totals.
// Reset clears the table count, both totals and the load stop mark; table
// contents need no clearing since only entries below the count are read.
// busy is high while a transaction runs; results cannot be stalled.
module address_region_table_lookup #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [63:0] address,
    input  logic [63:0] length,
    input  logic [7:0]  index,
    input  logic        committed,
    input  logic        readable_prot,
    input  logic        executable_prot,
    input  logic        blocked_prot,
    input  logic        private_type,
    output logic        done,
    output logic        hit,
    output logic        readable_ok,
    output logic        executable,
    output logic        priv_mark,
    output logic        merged,
    output logic [2:0]  status,
    output logic [63:0] region_start,
    output logic [63:0] region_end,
    output logic [8:0]  region_count,
    output logic [63:0] total_bytes,
    output logic [63:0] private_bytes
);
    import arlt_pkg::*;

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    // control state
    state_t         state_reg, state_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [63:0]    sum_reg, sum_next;
    logic [63:0]    psum_reg, psum_next;
    logic           stopped_reg, stopped_next;

    // captured command
    logic [63:0]    addr_reg, addr_next;
    logic [63:0]    len_reg, len_next;
    logic           ex_in_reg, ex_in_next;
    logic           prv_in_reg, prv_in_next;
    logic           usable_reg, usable_next;

    // search and scratch
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic           eq_reg, eq_next;
    logic [63:0]    acc_reg, acc_next;
    logic           carry_reg, carry_next;

    // copy of the last table entry for merge and order checks
    logic [63:0]    last_start_reg, last_start_next;
    logic [63:0]    last_end_reg, last_end_next;
    logic           last_ex_reg, last_ex_next;
    logic           last_prv_reg, last_prv_next;

    // result fields
    logic           hit_reg, hit_next;
    logic           rok_reg, rok_next;
    logic           ex_reg, ex_next;
    logic           prv_reg, prv_next;
    logic           mrg_reg, mrg_next;
    logic [2:0]     status_reg, status_next;
    logic [63:0]    rs_reg, rs_next;
    logic [63:0]    re_reg, re_next;

    // memory and adder hookup
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    entry_t         mem_wdata;
    logic [AW-1:0]  mem_raddr;
    entry_t         mem_rdata;
    alu_op_t        alu_op;
    logic [63:0]    alu_a;
    logic [63:0]    alu_b;
    alu_res_t       alu_res;

    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_c;
    logic [CW-1:0]  lo_m1;
    logic [CW-1:0]  count_m1;
    logic [63:0]    sat_c;
    logic           accept;

    assign accept   = start && (state_reg == S_IDLE);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c    = mid_sum[CW:1];
    assign lo_m1    = lo_reg - CW'(1);
    assign count_m1 = count_reg - CW'(1);
    assign sat_c    = alu_res.carry ? {64{1'b1}} : alu_res.value;

    arlt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    arlt_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Operand selection for the shared adder depends on state and registers only.
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = 64'd0;
        alu_b  = 64'd0;
        case (state_reg)
            S_AD_CHK:
            begin
                alu_op = ALU_SUB;
                alu_a  = addr_reg;
                alu_b  = last_end_reg;
            end
            S_AD_END:
            begin
                alu_a = addr_reg;
                alu_b = len_reg;
            end
            S_AD_SUM:
            begin
                alu_a = sum_reg;
                alu_b = len_reg;
            end
            S_AD_PSUM:
            begin
                alu_a = psum_reg;
                alu_b = len_reg;
            end
            S_CK_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = addr_reg;
                alu_b  = mem_rdata.base;
            end
            S_CK_IN:
            begin
                alu_op = ALU_SUB;
                alu_a  = addr_reg;
                alu_b  = mem_rdata.limit;
            end
            S_CK_TOP:
            begin
                alu_a = addr_reg;
                alu_b = len_reg;
            end
            S_CK_FIT:
            begin
                alu_op = ALU_SUB;
                alu_a  = re_reg;
                alu_b  = acc_reg;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Sequencer: next state, register updates, memory strobes.
    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        count_next      = count_reg;
        sum_next        = sum_reg;
        psum_next       = psum_reg;
        stopped_next    = stopped_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        ex_in_next      = ex_in_reg;
        prv_in_next     = prv_in_reg;
        usable_next     = usable_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        eq_next         = eq_reg;
        acc_next        = acc_reg;
        carry_next      = carry_reg;
        last_start_next = last_start_reg;
        last_end_next   = last_end_reg;
        last_ex_next    = last_ex_reg;
        last_prv_next   = last_prv_reg;
        hit_next        = hit_reg;
        rok_next        = rok_reg;
        ex_next         = ex_reg;
        prv_next        = prv_reg;
        mrg_next        = mrg_reg;
        status_next     = status_reg;
        rs_next         = rs_reg;
        re_next         = re_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                // read entry fetch goes out in the accept cycle
                mem_raddr = AW'(index);
                if (accept)
                begin
                    addr_next   = address;
                    len_next    = length;
                    ex_in_next  = executable_prot;
                    prv_in_next = private_type;
                    usable_next = committed && readable_prot && !blocked_prot;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    hit_next    = 1'b0;
                    rok_next    = 1'b0;
                    ex_next     = 1'b0;
                    prv_next    = 1'b0;
                    mrg_next    = 1'b0;
                    status_next = STAT_OK;
                    rs_next     = 64'd0;
                    re_next     = 64'd0;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            sum_next     = 64'd0;
                            psum_next    = 64'd0;
                            stopped_next = 1'b0;
                            done_next    = 1'b1;
                        end
                        OP_ADD:
                        begin
                            state_next = S_AD_CHK;
                        end
                        OP_CHECK:
                        begin
                            state_next = S_CK_MID;
                        end
                        default:
                        begin
                            hit_next   = CMPW'(index) < CMPW'(count_reg);
                            state_next = S_RD_OUT;
                        end
                    endcase
                end
            end

            S_RD_OUT:
            begin
                if (hit_reg)
                begin
                    ex_next  = mem_rdata.exec;
                    prv_next = mem_rdata.priv;
                    rs_next  = mem_rdata.base;
                    re_next  = mem_rdata.limit;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_AD_CHK:
            begin
                if (stopped_reg)
                begin
                    status_next = STAT_STOPPED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (len_reg == 64'd0)
                begin
                    stopped_next = 1'b1;
                    status_next  = STAT_ZERO;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (!usable_reg || (count_reg != '0 && alu_res.carry))
                begin
                    // unusable, or below the end of the last entry
                    status_next = STAT_UNUSABLE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    eq_next    = (count_reg != '0) && alu_res.zero;
                    state_next = S_AD_END;
                end
            end

            S_AD_END:
            begin
                if (eq_reg && (last_ex_reg == ex_in_reg) && (last_prv_reg == prv_in_reg))
                begin
                    // extend the last entry in place
                    mem_we          = 1'b1;
                    mem_waddr       = count_m1[AW-1:0];
                    mem_wdata.base  = last_start_reg;
                    mem_wdata.limit = sat_c;
                    mem_wdata.exec  = last_ex_reg;
                    mem_wdata.priv  = last_prv_reg;
                    last_end_next   = sat_c;
                    mrg_next        = 1'b1;
                    hit_next        = 1'b1;
                    state_next      = S_AD_SUM;
                end
                else if (count_reg >= CW'(TABLE_ENTRIES))
                begin
                    status_next = STAT_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = count_reg[AW-1:0];
                    mem_wdata.base  = addr_reg;
                    mem_wdata.limit = sat_c;
                    mem_wdata.exec  = ex_in_reg;
                    mem_wdata.priv  = prv_in_reg;
                    last_start_next = addr_reg;
                    last_end_next   = sat_c;
                    last_ex_next    = ex_in_reg;
                    last_prv_next   = prv_in_reg;
                    count_next      = count_reg + CW'(1);
                    hit_next        = 1'b1;
                    state_next      = S_AD_SUM;
                end
            end

            S_AD_SUM:
            begin
                sum_next = sat_c;
                if (prv_in_reg)
                begin
                    state_next = S_AD_PSUM;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_AD_PSUM:
            begin
                psum_next  = sat_c;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_CK_MID:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_raddr  = mid_c[AW-1:0];
                    mid_next   = mid_c;
                    state_next = S_CK_CMP;
                end
                else if (lo_reg == '0)
                begin
                    // address lies below every region
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_raddr  = lo_m1[AW-1:0];
                    state_next = S_CK_IN;
                end
            end

            S_CK_CMP:
            begin
                if (alu_res.carry)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CW'(1);
                end
                state_next = S_CK_MID;
            end

            S_CK_IN:
            begin
                // start is already known to be at or below the address
                if (alu_res.carry)
                begin
                    hit_next = 1'b1;
                    ex_next  = mem_rdata.exec;
                    prv_next = mem_rdata.priv;
                    rs_next  = mem_rdata.base;
                    re_next  = mem_rdata.limit;
                    if (addr_reg != 64'd0 && len_reg != 64'd0)
                    begin
                        state_next = S_CK_TOP;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_CK_TOP:
            begin
                acc_next   = alu_res.value;
                carry_next = alu_res.carry;
                state_next = S_CK_FIT;
            end

            S_CK_FIT:
            begin
                rok_next   = !carry_reg && !alu_res.carry;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= 64'd0;
            psum_reg    <= 64'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= done_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            psum_reg    <= psum_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        ex_in_reg      <= ex_in_next;
        prv_in_reg     <= prv_in_next;
        usable_reg     <= usable_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        eq_reg         <= eq_next;
        acc_reg        <= acc_next;
        carry_reg      <= carry_next;
        last_start_reg <= last_start_next;
        last_end_reg   <= last_end_next;
        last_ex_reg    <= last_ex_next;
        last_prv_reg   <= last_prv_next;
        hit_reg        <= hit_next;
        rok_reg        <= rok_next;
        ex_reg         <= ex_next;
        prv_reg        <= prv_next;
        mrg_reg        <= mrg_next;
        status_reg     <= status_next;
        rs_reg         <= rs_next;
        re_reg         <= re_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign readable_ok   = rok_reg;
    assign executable    = ex_reg;
    assign priv_mark     = prv_reg;
    assign merged        = mrg_reg;
    assign status        = status_reg;
    assign region_start  = rs_reg;
    assign region_end    = re_reg;
    assign region_count  = 9'(count_reg);
    assign total_bytes   = sum_reg;
    assign private_bytes = psum_reg;

`ifndef SYNTHESIS
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE || accept))
        else $error("done without a running transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("table count above capacity");

    a_merge_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && mrg_reg) |-> (hit_reg && status_reg == STAT_OK))
        else $error("merge reported without a stored add");

    a_fit_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rok_reg) |-> hit_reg)
        else $error("range fit reported without a found region");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CK_MID) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("binary search window out of order");
`endif

endmodule

### bench/region_lookup_tb_pkg.sv
// Transaction types and the scoreboard class for the address region table bench.
package region_lookup_tb_pkg;
    import arlt_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        opcode_t     op;
        logic [63:0] address;
        logic [63:0] length;
        logic [7:0]  index;
        logic        committed;
        logic        readable_prot;
        logic        executable_prot;
        logic        blocked_prot;
        logic        private_type;
    } region_cmd_t;

    typedef struct packed {
        logic        hit;
        logic        readable_ok;
        logic        executable;
        logic        priv_mark;
        logic        merged;
        logic [2:0]  status;
        logic [63:0] region_start;
        logic [63:0] region_end;
        logic [8:0]  region_count;
        logic [63:0] total_bytes;
        logic [63:0] private_bytes;
    } region_res_t;

    typedef struct {
        opcode_t     op;
        int unsigned serial;
        region_res_t res;
    } lookup_expect_t;

    // Sum that sticks at all ones instead of wrapping.
    function automatic logic [63:0] clamp_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    class region_lookup_scoreboard;
        logic [63:0]    base_mem [TABLE_DEPTH];
        logic [63:0]    limit_mem[TABLE_DEPTH];
        logic           exec_mem [TABLE_DEPTH];
        logic           priv_mem [TABLE_DEPTH];
        int unsigned    held;
        logic [63:0]    byte_sum;
        logic [63:0]    private_sum;
        bit             loading_stopped;
        lookup_expect_t awaited[$];
        int unsigned    accepted;
        int unsigned    mismatches;

        function new();
            held            = 0;
            byte_sum        = '0;
            private_sum     = '0;
            loading_stopped = 1'b0;
            accepted        = 0;
            mismatches      = 0;
        endfunction

        // Advance the table copy by one command and return the result it must produce.
        function region_res_t predict_lookup(region_cmd_t c);
            region_res_t r;
            logic [63:0] stop;
            logic [64:0] reach;
            bit          stored;
            int          lo;
            int          hi;
            int          mid;
            r = '0;
            case (c.op)
                OP_CLEAR:
                begin
                    held            = 0;
                    byte_sum        = '0;
                    private_sum     = '0;
                    loading_stopped = 1'b0;
                end
                OP_ADD:
                begin
                    if (loading_stopped)
                    begin
                        r.status = STAT_STOPPED;
                    end
                    else if (c.length == '0)
                    begin
                        loading_stopped = 1'b1;
                        r.status        = STAT_ZERO;
                    end
                    else if (!c.committed || !c.readable_prot || c.blocked_prot ||
                             (held > 0 && c.address < limit_mem[held - 1]))
                    begin
                        r.status = STAT_UNUSABLE;
                    end
                    else
                    begin
                        stop   = clamp_sum(c.address, c.length);
                        stored = 1'b0;
                        if (held > 0 && limit_mem[held - 1] == c.address &&
                            exec_mem[held - 1] == c.executable_prot &&
                            priv_mem[held - 1] == c.private_type)
                        begin
                            limit_mem[held - 1] = stop;
                            r.merged            = 1'b1;
                            stored              = 1'b1;
                        end
                        if (!stored)
                        begin
                            if (held >= TABLE_DEPTH)
                            begin
                                r.status = STAT_FULL;
                            end
                            else
                            begin
                                base_mem[held]  = c.address;
                                limit_mem[held] = stop;
                                exec_mem[held]  = c.executable_prot;
                                priv_mem[held]  = c.private_type;
                                held++;
                                stored = 1'b1;
                            end
                        end
                        if (stored)
                        begin
                            r.hit    = 1'b1;
                            byte_sum = clamp_sum(byte_sum, c.length);
                            if (c.private_type)
                                private_sum = clamp_sum(private_sum, c.length);
                        end
                    end
                end
                OP_CHECK:
                begin
                    lo = 0;
                    hi = held;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (c.address < base_mem[mid])
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    lo = lo - 1;
                    if (lo >= 0 && c.address >= base_mem[lo] && c.address < limit_mem[lo])
                    begin
                        r.hit          = 1'b1;
                        r.executable   = exec_mem[lo];
                        r.priv_mark    = priv_mem[lo];
                        r.region_start = base_mem[lo];
                        r.region_end   = limit_mem[lo];
                        reach          = {1'b0, c.address} + {1'b0, c.length};
                        if (c.address != '0 && c.length != '0 && reach <= {1'b0, limit_mem[lo]})
                            r.readable_ok = 1'b1;
                    end
                end
                default:
                begin
                    if (c.index < held)
                    begin
                        r.hit          = 1'b1;
                        r.executable   = exec_mem[c.index];
                        r.priv_mark    = priv_mem[c.index];
                        r.region_start = base_mem[c.index];
                        r.region_end   = limit_mem[c.index];
                    end
                end
            endcase
            r.region_count  = 9'(held);
            r.total_bytes   = byte_sum;
            r.private_bytes = private_sum;
            return r;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task note_command(region_cmd_t c);
            lookup_expect_t pending;
            pending.op     = c.op;
            pending.serial = accepted;
            pending.res    = predict_lookup(c);
            awaited        = {awaited, pending};
            accepted++;
        endtask

        task compare_field(string tag, string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                report_mismatch($sformatf("%s %s: expected %0h, got %0h", tag, field, want, got));
        endtask

        task check_result(region_res_t got);
            lookup_expect_t want;
            string          tag;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result with no transaction outstanding (count %0d)",
                                          got.region_count));
                return;
            end
            want = awaited.pop_front();
            tag  = $sformatf("transaction %0d %s", want.serial, want.op.name());
            compare_field(tag, "hit",           64'(want.res.hit),          64'(got.hit));
            compare_field(tag, "readable_ok",   64'(want.res.readable_ok),  64'(got.readable_ok));
            compare_field(tag, "executable",    64'(want.res.executable),   64'(got.executable));
            compare_field(tag, "priv_mark",     64'(want.res.priv_mark),    64'(got.priv_mark));
            compare_field(tag, "merged",        64'(want.res.merged),       64'(got.merged));
            compare_field(tag, "status",        64'(want.res.status),       64'(got.status));
            compare_field(tag, "region_start",  want.res.region_start,      got.region_start);
            compare_field(tag, "region_end",    want.res.region_end,        got.region_end);
            compare_field(tag, "region_count",  64'(want.res.region_count), 64'(got.region_count));
            compare_field(tag, "total_bytes",   want.res.total_bytes,       got.total_bytes);
            compare_field(tag, "private_bytes", want.res.private_bytes,     got.private_bytes);
        endtask
    endclass

endpackage

### bench/tb_top.sv
// Top of the address region table bench: clock, reset, stimulus, result monitor and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import arlt_pkg::*;
    import region_lookup_tb_pkg::*;

    // Mark bits in the order committed, readable, executable, blocked, private.
    localparam logic [4:0] MARK_COMMITTED = 5'b10000;
    localparam logic [4:0] MARK_READABLE  = 5'b01000;
    localparam logic [4:0] MARK_EXEC      = 5'b00100;
    localparam logic [4:0] MARK_BLOCKED   = 5'b00010;
    localparam logic [4:0] MARK_PRIVATE   = 5'b00001;
    localparam logic [4:0] MARK_USABLE    = MARK_COMMITTED | MARK_READABLE;

    localparam int ITEMS_PER_PHASE = 110;
    localparam int TAIL_CYCLES     = 32;   // longer than the slowest check on a full table

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [63:0] length;
    logic [7:0]  index;
    logic        committed;
    logic        readable_prot;
    logic        executable_prot;
    logic        blocked_prot;
    logic        private_type;
    logic        done;
    logic        hit;
    logic        readable_ok;
    logic        executable;
    logic        priv_mark;
    logic        merged;
    logic [2:0]  status;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [8:0]  region_count;
    logic [63:0] total_bytes;
    logic [63:0] private_bytes;

    region_lookup_scoreboard lookups;
    region_res_t             observed;

    // Stimulus bookkeeping: the end of the last region the table should hold, the
    // marks it carries, and the regions added since the last clear, so that checks
    // can aim inside, at the edges of, and just past real regions.
    logic [63:0] cursor;
    logic [4:0]  last_marks;
    logic [63:0] known_base[$];
    logic [63:0] known_len[$];
    int unsigned sender_idle_pct;
    int unsigned items_sent;

    address_region_table_lookup #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .address         (address),
        .length          (length),
        .index           (index),
        .committed       (committed),
        .readable_prot   (readable_prot),
        .executable_prot (executable_prot),
        .blocked_prot    (blocked_prot),
        .private_type    (private_type),
        .done            (done),
        .hit             (hit),
        .readable_ok     (readable_ok),
        .executable      (executable),
        .priv_mark       (priv_mark),
        .merged          (merged),
        .status          (status),
        .region_start    (region_start),
        .region_end      (region_end),
        .region_count    (region_count),
        .total_bytes     (total_bytes),
        .private_bytes   (private_bytes)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic region_cmd_t make_cmd(opcode_t op, logic [63:0] addr, logic [63:0] len,
                                             logic [7:0] idx, logic [4:0] marks);
        region_cmd_t c;
        c.op      = op;
        c.address = addr;
        c.length  = len;
        c.index   = idx;
        {c.committed, c.readable_prot, c.executable_prot, c.blocked_prot, c.private_type} = marks;
        return c;
    endfunction

    // Drive one transaction and hold it until the block takes it. Called at a rising
    // edge; start is left high on return so that a back-to-back transaction does not
    // lower and raise it in the same step. An idle gap lowers it first.
    task automatic issue(region_cmd_t c);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        opcode          <= c.op;
        address         <= c.address;
        length          <= c.length;
        index           <= c.index;
        committed       <= c.committed;
        readable_prot   <= c.readable_prot;
        executable_prot <= c.executable_prot;
        blocked_prot    <= c.blocked_prot;
        private_type    <= c.private_type;
        // The values read here are the ones the block sampled at this edge.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        lookups.note_command(c);
        items_sent++;
    endtask

    // Fields that an opcode ignores get random content throughout.
    task automatic send_clear();
        issue(make_cmd(OP_CLEAR, rand64(), rand64(), 8'($urandom), 5'($urandom)));
        known_base.delete();
        known_len.delete();
        cursor = '0;
    endtask

    task automatic send_check(logic [63:0] addr, logic [63:0] len);
        issue(make_cmd(OP_CHECK, addr, len, 8'($urandom), 5'($urandom)));
    endtask

    task automatic send_read(logic [7:0] idx);
        issue(make_cmd(OP_READ, rand64(), rand64(), idx, 5'($urandom)));
    endtask

    // Track the cursor only for adds that should land in the table; a rough view
    // is enough since it only steers stimulus, never the expected results.
    task automatic send_add(logic [63:0] addr, logic [63:0] len, logic [4:0] marks);
        issue(make_cmd(OP_ADD, addr, len, 8'($urandom), marks));
        if ((marks & MARK_USABLE) == MARK_USABLE && (marks & MARK_BLOCKED) == 5'd0 &&
            len != '0 && addr >= cursor)
        begin
            known_base = {known_base, addr};
            known_len  = {known_len, len};
            if (known_base.size() > 320)
            begin
                void'(known_base.pop_front());
                void'(known_len.pop_front());
            end
            cursor     = clamp_sum(addr, len);
            last_marks = marks;
        end
    endtask

    // Mostly ascending usable adds, with contiguous ones that merge, gaps, huge
    // sizes, and a few broken ones: unusable marks, below the last end, zero size.
    task automatic random_add();
        logic [63:0] gap;
        logic [63:0] len;
        logic [63:0] addr;
        logic [4:0]  marks;
        int unsigned pick;
        case ($urandom_range(9))
            0, 1, 2, 3: gap = '0;
            4, 5, 6:    gap = 64'($urandom_range(1, 256));
            7, 8:       gap = 64'($urandom_range(1, 1 << 20));
            default:    gap = rand64() >> $urandom_range(8, 40);
        endcase
        pick = $urandom_range(99);
        if (pick < 80)
            len = 64'($urandom_range(1, 4096));
        else if (pick < 95)
            len = {32'd0, $urandom} + 64'd1;
        else
            len = rand64();
        marks = last_marks;
        if ($urandom_range(2) == 0)
            marks = MARK_USABLE | ($urandom_range(1) ? MARK_EXEC : 5'd0) |
                    ($urandom_range(1) ? MARK_PRIVATE : 5'd0);
        addr = cursor + gap;
        pick = $urandom_range(99);
        if (pick < 8)
            marks = 5'($urandom);
        else if (pick < 11)
            addr = cursor - 64'($urandom_range(1, 4096));
        else if (pick < 13)
            len = '0;
        send_add(addr, len, marks);
    endtask

    // Aim most checks inside known regions, with lengths that fit, end exactly on
    // the region end, overshoot by one, are zero or are wild; some hit the edges.
    task automatic random_check();
        logic [63:0] addr;
        logic [63:0] len;
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] off;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        addr = rand64();
        len  = rand64();
        if (known_base.size() != 0 && pick < 85)
        begin
            k    = $urandom_range(known_base.size() - 1);
            base = known_base[k];
            span = known_len[k];
            off  = rand64() % span;
            addr = base + off;
            case ($urandom_range(9))
                0, 1, 2, 3: len = 64'($urandom_range(1, 256));
                4, 5:       len = span - off;
                6:          len = span - off + 64'd1;
                7:          len = '0;
                default:    len = rand64();
            endcase
            if (pick >= 70)
                addr = $urandom_range(1) ? base - 64'd1 : base + span;
        end
        else if (pick < 90)
        begin
            addr = '0;
        end
        send_check(addr, len);
    endtask

    // One loading session: usually start from a clear at a random base, then a mix
    // of adds, checks, reads, the odd clear and some fully random transactions.
    task automatic random_session(int unsigned n);
        int unsigned pick;
        logic [7:0]  idx;
        if ($urandom_range(9) != 0)
        begin
            send_clear();
            cursor = rand64() >> $urandom_range(1, 48);
        end
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                random_add();
            end
            else if (pick < 78)
            begin
                random_check();
            end
            else if (pick < 90)
            begin
                idx = ($urandom_range(2) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(lookups.held + 1));
                send_read(idx);
            end
            else if (pick < 93)
            begin
                send_clear();
            end
            else if (pick < 96)
            begin
                send_add(rand64(), rand64(), 5'($urandom));
            end
            else
            begin
                issue(make_cmd(opcode_t'($urandom_range(3)), rand64(), rand64(),
                               8'($urandom), 5'($urandom)));
            end
        end
    endtask

    // Fill every slot with small regions whose executable mark alternates, so none
    // merge, run a few past the end for the table full case, merge into the last
    // stored entry while full, then search the full table.
    task automatic fill_table();
        logic [4:0]  marks;
        logic [63:0] addr;
        logic [63:0] full_end;
        logic [4:0]  full_marks;
        send_clear();
        cursor     = rand64() >> 24;
        full_end   = '0;
        full_marks = MARK_USABLE;
        for (int i = 0; i < TABLE_DEPTH + 4; i++)
        begin
            marks = MARK_USABLE | (i[0] ? MARK_EXEC : 5'd0) |
                    ($urandom_range(1) ? MARK_PRIVATE : 5'd0);
            addr  = cursor + 64'($urandom_range(1) ? 0 : $urandom_range(1, 32));
            send_add(addr, 64'($urandom_range(1, 64)), marks);
            if (i == TABLE_DEPTH - 1)
            begin
                full_end   = cursor;
                full_marks = last_marks;
            end
        end
        send_add(full_end, 64'($urandom_range(1, 64)), full_marks);
        repeat (24)
        begin
            if ($urandom_range(2) == 0)
                send_read(8'($urandom));
            else
                random_check();
        end
    endtask

    // Results cannot be held off: sample every done cycle at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            observed.hit           = hit;
            observed.readable_ok   = readable_ok;
            observed.executable    = executable;
            observed.priv_mark     = priv_mark;
            observed.merged        = merged;
            observed.status        = status;
            observed.region_start  = region_start;
            observed.region_end    = region_end;
            observed.region_count  = region_count;
            observed.total_bytes   = total_bytes;
            observed.private_bytes = private_bytes;
            lookups.check_result(observed);
        end
    end

    initial
    begin
        int unsigned phase_idle[5];
        int unsigned target;
        lookups         = new();
        cursor          = '0;
        last_marks      = MARK_USABLE;
        items_sent      = 0;
        sender_idle_pct = 0;
        rst_n           <= 1'b0;
        start           <= 1'b0;
        opcode          <= OP_CLEAR;
        address         <= '0;
        length          <= '0;
        index           <= '0;
        committed       <= 1'b0;
        readable_prot   <= 1'b0;
        executable_prot <= 1'b0;
        blocked_prot    <= 1'b0;
        private_type    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, merge and append, every unusable reason, fit and
        // overshoot, gap miss, zero length, reads past the count, saturating end
        // and totals, check range overflow, zero size stop, adds while stopped,
        // and a region at address zero.
        send_read(8'd0);
        send_check(64'h1800, 64'h10);
        send_add(64'h1000, 64'h1000, MARK_USABLE);
        send_add(64'h2000, 64'h800, MARK_USABLE);
        send_add(64'h2800, 64'h100, MARK_USABLE | MARK_EXEC);
        send_add(64'h4000, 64'h100, MARK_USABLE | MARK_PRIVATE);
        send_add(64'h3000, 64'h100, MARK_USABLE);
        send_add(64'h5000, 64'h100, MARK_READABLE);
        send_add(64'h5000, 64'h100, MARK_COMMITTED);
        send_add(64'h5000, 64'h100, MARK_USABLE | MARK_BLOCKED);
        send_check(64'h1800, 64'h100);
        send_check(64'h1800, 64'h1001);
        send_check(64'h3000, 64'h10);
        send_check(64'h1800, 64'h0);
        send_read(8'd3);
        send_read(8'd4);
        send_read(8'hFF);
        send_add(64'hFFFF_FFFF_FFFF_F000, {64{1'b1}}, MARK_USABLE | MARK_EXEC | MARK_PRIVATE);
        send_check(64'hFFFF_FFFF_FFFF_F800, {64{1'b1}});
        send_check({64{1'b1}}, 64'h1);
        send_add(rand64(), 64'h0, MARK_USABLE);
        send_add(64'h8000, 64'h10, MARK_USABLE);
        send_clear();
        send_add(64'h0, 64'h10, MARK_USABLE | MARK_PRIVATE);
        send_check(64'h0, 64'h4);
        send_check(64'h4, 64'hC);

        // Random phases: no idling, heavy sender idling, moderate idling with the
        // full table pass, no idling again, heavy idling again.
        phase_idle = '{0, 67, 34, 0, 67};
        foreach (phase_idle[p])
        begin
            sender_idle_pct = phase_idle[p];
            target          = items_sent + ITEMS_PER_PHASE;
            if (p == 2)
                fill_table();
            while (items_sent < target)
                random_session($urandom_range(10, 60));
        end
        start <= 1'b0;

        // Drop nothing: wait for every outstanding result, then watch for strays.
        while (lookups.awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (lookups.mismatches == 0 && lookups.awaited.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin
        #1000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
